[rtl/fir_filter_clamped_12bit_assert.svh]
// ----------------------------------------------------------------------------
// fir filter assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CLAMPED_12BIT_ASSERT_SVH
`define FIR_FILTER_CLAMPED_12BIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define FCF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcf check failed");

// antecedent implies consequent in the next cycle
`define FCF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcf check failed");

`else

`define FCF_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define FCF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/fcf_pkg.sv]
// ----------------------------------------------------------------------------
// fcf_pkg
// widths, register indexes and reset values of the clamped fir filter
// ----------------------------------------------------------------------------
package fcf_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int COEF_W    = 16;
   localparam int COEF_REGS = 3;
   localparam int FRAC_BITS = 12;
   // unsigned sample widened by one sign bit, times a signed coefficient
   localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
   // at most three weighted taps
   localparam int SUM_W     = PROD_W + 2;
   localparam int WHOLE_W   = SUM_W - 1 - FRAC_BITS;
   localparam int CSR_IDX_W = 2;

   localparam logic [SAMPLE_W-1:0] OUT_MAX = 12'hFFF;

   localparam logic [COEF_W-1:0] COEF_NEWEST_RST = 16'h1000;
   localparam logic [COEF_W-1:0] COEF_MIDDLE_RST = 16'h0000;
   localparam logic [COEF_W-1:0] COEF_OLDEST_RST = 16'h0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_NEWEST = 2'd0,
      CSR_COEF_MIDDLE = 2'd1,
      CSR_COEF_OLDEST = 2'd2
   } csr_index_type;

   typedef logic [COEF_REGS-1:0][COEF_W-1:0] coef_bank_type;

endpackage

[rtl/fcf_delay_line.sv]
// ----------------------------------------------------------------------------
// fcf_delay_line
// sample history, newest in slot zero, shifted once per accepted sample
// ----------------------------------------------------------------------------
module fcf_delay_line
   import fcf_pkg::*;
#(
   parameter int DEPTH = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift_en,
   input  logic [SAMPLE_W-1:0]             sample_in,
   output logic [DEPTH-1:0][SAMPLE_W-1:0]  taps
);

   logic [DEPTH-1:0][SAMPLE_W-1:0] history_ff;
   logic [DEPTH-1:0][SAMPLE_W-1:0] history_in;

   always_comb begin
      history_in = history_ff;
      if (shift_en) begin
         history_in[0] = sample_in;
         for (int i = 1; i < DEPTH; i++) begin
            history_in[i] = history_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else begin
         history_ff <= history_in;
      end
   end

   assign taps = history_ff;

endmodule

[rtl/fcf_mac.sv]
// ----------------------------------------------------------------------------
// fcf_mac
// weighted sum of the taps at full precision, clamped to the output range
// ----------------------------------------------------------------------------
module fcf_mac
   import fcf_pkg::*;
#(
   parameter int TAPS = 3
) (
   input  logic [TAPS-1:0][SAMPLE_W-1:0] taps,
   input  coef_bank_type                 coefs,
   output logic [SAMPLE_W-1:0]           filtered
);

   logic signed [PROD_W-1:0] prod [TAPS];
   logic signed [SUM_W-1:0]  acc;
   logic [WHOLE_W-1:0]       whole;

   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      assign prod[k] = $signed({1'b0, taps[k]}) * $signed(coefs[k]);
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
         acc = acc + {{(SUM_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
      end
   end

   // drop the fraction, sign bit handled by the clamp
   assign whole = acc[SUM_W-2:FRAC_BITS];

   always_comb begin
      if (acc[SUM_W-1]) begin
         filtered = '0;
      end else if (|whole[WHOLE_W-1:SAMPLE_W]) begin
         filtered = OUT_MAX;
      end else begin
         filtered = whole[SAMPLE_W-1:0];
      end
   end

endmodule

[rtl/fir_filter_clamped_12bit.sv]
// accepted samples enter the history stage, their filtered values the result stage
// throughput: one sample per cycle unless stalled, set by the single history and result stage
// req_stall rises only while a result is held on rsp and the history stage is full
// reset clears the sample history, the valid flags and sets coef_newest to 1.0
// ----------------------------------------------------------------------------
// fir_filter_clamped_12bit
// three-tap fir on unsigned 12-bit samples with q4.12 weights and clamped output
// ----------------------------------------------------------------------------
`include "fir_filter_clamped_12bit_assert.svh"

module fir_filter_clamped_12bit
   import fcf_pkg::*;
#(
   parameter int TAP_COUNT = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_sample_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SAMPLE_W-1:0]  rsp_filtered_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   // only the first three taps carry a weight
   localparam int MAC_TAPS = (TAP_COUNT < COEF_REGS) ? TAP_COUNT : COEF_REGS;

   coef_bank_type coef_ff;
   coef_bank_type coef_in;

   logic                 hist_valid_ff;
   logic                 hist_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [SAMPLE_W-1:0]  filtered_ff;
   logic [SAMPLE_W-1:0]  filtered_in;

   logic                 req_take;
   logic                 rsp_take;
   logic                 out_free;
   logic                 hist_move;
   logic [MAC_TAPS-1:0][SAMPLE_W-1:0] taps;
   logic [SAMPLE_W-1:0]  mac_result;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COEF_NEWEST: coef_in[0] = csr_data;
            CSR_COEF_MIDDLE: coef_in[1] = csr_data;
            CSR_COEF_OLDEST: coef_in[2] = csr_data;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= COEF_NEWEST_RST;
         coef_ff[1] <= COEF_MIDDLE_RST;
         coef_ff[2] <= COEF_OLDEST_RST;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hist_move = hist_valid_ff && out_free;
   assign req_stall = hist_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign hist_valid_in = req_take || (hist_valid_ff && !out_free);
   assign rsp_valid_in  = hist_move || (rsp_valid_ff && !rsp_take);
   assign filtered_in   = hist_move ? mac_result : filtered_ff;

   fcf_delay_line #(
      .DEPTH     (MAC_TAPS)
   ) u_delay_line (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_take),
      .sample_in (req_sample_in),
      .taps      (taps)
   );

   fcf_mac #(
      .TAPS      (MAC_TAPS)
   ) u_mac (
      .taps      (taps),
      .coefs     (coef_ff),
      .filtered  (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hist_valid_ff <= hist_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      filtered_ff <= filtered_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = filtered_ff;

   // a transaction on req always lands in the history stage
   `FCF_ASSERT_NEXT(a_req_to_hist, clock, reset, req_take, hist_valid_ff)
   // a history item moving on always shows up as a result
   `FCF_ASSERT_NEXT(a_hist_to_rsp, clock, reset, hist_move, rsp_valid_ff)
   // with nothing behind it, a taken result leaves the output empty
   `FCF_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_take && !hist_valid_ff, !rsp_valid_ff)
   // the history stage never back-pressures while the output is free
   `FCF_ASSERT_NOW(a_no_idle_stall, clock, reset, !rsp_valid_ff, !req_stall)

endmodule

[tb/fir_filter_clamped_12bit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_clamped_12bit_tb
// streams samples through the three-tap clamped fir under several weight sets
// and checks every filtered value against a cycle-free predictor of the filter
// ----------------------------------------------------------------------------
module fir_filter_clamped_12bit_tb;
   import fcf_pkg::*;

   localparam int                   CLK_HALF     = 4;
   localparam int                   RAND_PHASES  = 9;
   localparam int                   PHASE_ITEMS  = 200;
   localparam int                   HOLD_CYCLES  = 80;
   localparam int                   HOLD_AT [2]  = '{300, 1500};
   localparam int                   SETTLE       = 4;
   localparam int                   CYCLE_LIMIT  = 200000;
   localparam int                   REPORT_MAX   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_sample_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_filtered_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]    csr_data = '0;

   // predictor state: newest sample first
   logic [SAMPLE_W-1:0]      tap_history [COEF_REGS];
   logic signed [COEF_W-1:0] coef_weight [COEF_REGS];

   logic [SAMPLE_W-1:0] sample_backlog [$];
   logic [SAMPLE_W-1:0] filtered_due [$];

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int samples_taken = 0;
   int mismatch_count = 0;
   int hold_left = 0;
   int hold_stage = 0;
   int cycle_count = 0;

   fir_filter_clamped_12bit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered_out (rsp_filtered_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // shift the sample in, weight the taps at full precision, then clamp
   function automatic logic [SAMPLE_W-1:0] filter_next(input logic [SAMPLE_W-1:0] sample);
      longint acc;
      longint whole;
      tap_history[2] = tap_history[1];
      tap_history[1] = tap_history[0];
      tap_history[0] = sample;
      acc = 0;
      for (int k = 0; k < COEF_REGS; k++)
         acc += longint'(tap_history[k]) * longint'(coef_weight[k]);
      if (acc < 0)
         return '0;
      whole = acc >>> FRAC_BITS;
      if (whole > longint'(OUT_MAX))
         return OUT_MAX;
      return whole[SAMPLE_W-1:0];
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      int sensible;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               3: return 16'h1000;
               default: return 16'hF000;
            endcase
         end
         1: return COEF_W'($urandom);
         default: begin
            // weights of a usable filter keep outputs mostly off the rails
            sensible = int'($urandom_range(0, 7168)) - 2048;
            return sensible[COEF_W-1:0];
         end
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? OUT_MAX : '0;
      return SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (int'(idx) < COEF_REGS)
         coef_weight[idx] = val;
   endtask

   task automatic write_bank(input logic [COEF_W-1:0] newest, input logic [COEF_W-1:0] middle,
                             input logic [COEF_W-1:0] oldest);
      write_coef(CSR_COEF_NEWEST, newest);
      write_coef(CSR_COEF_MIDDLE, middle);
      write_coef(CSR_COEF_OLDEST, oldest);
      @(negedge clock);
   endtask

   task automatic set_gap_mode(input int mode);
      case (mode)
         0: begin
            send_gap_pct = 32;
            recv_gap_pct = 61;
         end
         1: begin
            send_gap_pct = 61;
            recv_gap_pct = 32;
         end
         default: begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
      endcase
   endtask

   task automatic drain();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || filtered_due.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch: %s expected %0d got %0d", what, want, got);
   endtask

   // driver: a stalled transaction is held, otherwise the next sample may follow
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filtered_due.push_back(filter_next(req_sample_in));
            samples_taken <= samples_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_valid     <= 1'b1;
               req_sample_in <= sample_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin : result_check
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_due.size() == 0) begin
               note_mismatch("unexpected filtered_out", -1, int'(rsp_filtered_out));
            end else begin
               want = filtered_due.pop_front();
               if (rsp_filtered_out !== want)
                  note_mismatch("filtered_out", int'(want), int'(rsp_filtered_out));
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_gap_pct);
      end
   end

   // long receiver hold-off so the pipeline fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_stage <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_stage < 2 && samples_taken >= HOLD_AT[hold_stage]) begin
         hold_left  <= HOLD_CYCLES;
         hold_stage <= hold_stage + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < COEF_REGS; k++)
         tap_history[k] = '0;
      coef_weight[0] = COEF_NEWEST_RST;
      coef_weight[1] = COEF_MIDDLE_RST;
      coef_weight[2] = COEF_OLDEST_RST;
      set_gap_mode(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset weights pass samples straight through
      sample_backlog = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001};
      drain();

      // the write to the spare index must be ignored
      write_coef(CSR_UNUSED, 16'h1234);
      // steep weights: upper clamp, negative sum, half weight gives a fraction
      write_bank(16'h7FFF, 16'h8000, 16'h0800);
      sample_backlog = '{12'hFFF, 12'h000, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF};
      drain();

      // roughly a third on each tap, sums rarely whole
      write_bank(16'h0555, 16'h0555, 16'h0556);
      sample_backlog = '{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h001, 12'h002, 12'h003};
      drain();

      // a sum just below zero
      write_bank(16'hFFFF, 16'h0000, 16'h0000);
      sample_backlog = '{12'h001, 12'hFFF};
      drain();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         set_gap_mode(phase / 3);
         write_bank(pick_coef(), pick_coef(), pick_coef());
         for (int i = 0; i < PHASE_ITEMS; i++)
            sample_backlog.push_back(pick_sample());
         drain();
      end

      if (mismatch_count == 0 && filtered_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
